// File: hdl/kbsc_pkg.sv
package kbsc_pkg;

  localparam int BYTE_W    = 8;
  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int KEY_W     = 64;
  localparam int SEED_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [SEED_W-1:0] LCG_MUL    = 32'h0003_43fd;
  localparam logic [SEED_W-1:0] LCG_ADD    = 32'h0026_9ec3;
  localparam logic [KEY_W-1:0]  WHITEN_VEC = 64'h8ae6_9bf3_c17d_4025;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_seed;
    logic step_seed;
    logic k_clr;
    logic k_inc;
    logic fill_we;
    logic rd_k;
    logic rd_j;
    logic swap1_we;
    logic swap2_we;
    logic inv_we;
    logic clr_stale;
    logic accept;
    logic xform;
  } kbsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stale;
    logic k_last;
    logic cfg_we;
    logic out_busy;
  } kbsc_stat_t;

endpackage

// File: hdl/kbsc_ram.sv
module kbsc_ram #(
  parameter int DataW = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/kbsc_ctrl.sv
module kbsc_ctrl
  import kbsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kbsc_stat_t st,
  output kbsc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_STEP  = 4'd2;
  localparam logic [3:0] S_RDK   = 4'd3;
  localparam logic [3:0] S_RDJ   = 4'd4;
  localparam logic [3:0] S_SWAP1 = 4'd5;
  localparam logic [3:0] S_SWAP2 = 4'd6;
  localparam logic [3:0] S_INVR  = 4'd7;
  localparam logic [3:0] S_INVW  = 4'd8;
  localparam logic [3:0] S_XFORM = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       rebuilding;

  assign in_ready = (state_r == S_IDLE) && !st.stale && !st.out_busy && !st.cfg_we;
  assign rebuilding = (state_r != S_IDLE) && (state_r != S_XFORM);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_nxt  = S_XFORM;
        end else if (st.stale && !st.cfg_we) begin
          cmd.load_seed = 1'b1;
          cmd.k_clr     = 1'b1;
          state_nxt     = S_FILL;
        end
      end
      S_XFORM: begin
        cmd.xform = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        cmd.fill_we = 1'b1;
        if (st.k_last) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_STEP;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_STEP: begin
        cmd.step_seed = 1'b1;
        state_nxt     = S_RDK;
      end
      S_RDK: begin
        cmd.rd_k  = 1'b1;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_SWAP1;
      end
      S_SWAP1: begin
        cmd.swap1_we = 1'b1;
        state_nxt    = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.swap2_we = 1'b1;
        if (st.k_last) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_INVR;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_INVR: begin
        cmd.rd_k  = 1'b1;
        state_nxt = S_INVW;
      end
      S_INVW: begin
        cmd.inv_we = 1'b1;
        if (st.k_last) begin
          cmd.clr_stale = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_INVR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a new key or mode mid-rebuild: drop the pass and start over
    if (rebuilding && st.cfg_we) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/kbsc_dp.sv
module kbsc_dp
  import kbsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_message_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  input  kbsc_cmd_t            cmd,
  output kbsc_stat_t           st
);

  logic [KEY_W-1:0]  key_r;
  logic              enc_r;
  logic              stale_r;
  logic [BYTE_W-1:0] pos_r;
  logic [SEED_W-1:0] seed_r;
  logic [TBL_AW-1:0] k_r;
  logic [BYTE_W-1:0] tmp_r;
  logic [BYTE_W-1:0] p_r;
  logic [BYTE_W-1:0] w_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_valid_r;

  logic [KEY_W-1:0]  wkey;
  logic [TBL_AW-1:0] j;
  logic [BYTE_W-1:0] p_in, w_in;
  logic [TBL_AW-1:0] enc_addr, dec_addr;
  logic [TBL_AW-1:0] fwd_raddr, fwd_waddr;
  logic [BYTE_W-1:0] fwd_wdata, fwd_q, inv_q;
  logic              fwd_we;

  assign wkey = key_r ^ WHITEN_VEC;
  assign j    = seed_r[23:16];

  // key byte 0 sits in the top bits
  assign p_in     = in_message_start ? '0 : pos_r;
  assign w_in     = wkey[{~p_in[2:0], 3'b000} +: BYTE_W];
  assign enc_addr = in_data_byte ^ p_in ^ w_in;
  assign dec_addr = in_data_byte ^ w_in;

  always_comb begin
    priority if (cmd.rd_k) begin
      fwd_raddr = k_r;
    end else if (cmd.rd_j) begin
      fwd_raddr = j;
    end else begin
      fwd_raddr = enc_addr;
    end
  end

  assign fwd_we    = cmd.fill_we | cmd.swap1_we | cmd.swap2_we;
  assign fwd_waddr = cmd.swap2_we ? j : k_r;
  always_comb begin
    priority if (cmd.fill_we) begin
      fwd_wdata = k_r;
    end else if (cmd.swap1_we) begin
      fwd_wdata = fwd_q;
    end else begin
      fwd_wdata = tmp_r;
    end
  end

  kbsc_ram #(.DataW(BYTE_W), .Depth(TBL_DEPTH)) u_fwd (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (fwd_raddr),
    .rdata (fwd_q)
  );

  kbsc_ram #(.DataW(BYTE_W), .Depth(TBL_DEPTH)) u_inv (
    .clk   (clk),
    .we    (cmd.inv_we),
    .waddr (fwd_q),
    .wdata (k_r),
    .raddr (dec_addr),
    .rdata (inv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      enc_r       <= 1'b1;
      stale_r     <= 1'b1;
      pos_r       <= '0;
      seed_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY:  key_r <= cfg_wdata;
          REG_MODE: enc_r <= cfg_wdata[0];
          default:  key_r <= key_r;
        endcase
        stale_r <= 1'b1;
      end else if (cmd.clr_stale) begin
        stale_r <= 1'b0;
      end
      if (cmd.load_seed) begin
        seed_r <= wkey[63:32] ^ wkey[31:0];
      end else if (cmd.step_seed) begin
        seed_r <= seed_r * LCG_MUL + LCG_ADD;
      end
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.accept) begin
        pos_r <= p_in + 1'b1;
      end
      if (cmd.xform) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // hold fwd[k] across the read of fwd[j]
    if (cmd.rd_j) begin
      tmp_r <= fwd_q;
    end
    if (cmd.accept) begin
      p_r <= p_in;
      w_r <= w_in;
    end
    if (cmd.xform) begin
      out_byte_r <= enc_r ? (fwd_q ^ w_r) : (inv_q ^ w_r ^ p_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign st.stale    = stale_r;
  assign st.k_last   = &k_r;
  assign st.cfg_we   = cfg_we;
  assign st.out_busy = out_valid_r && !out_ready;

endmodule

// File: hdl/keyed_byte_substitution_cipher.sv
// Channel   Ports                                   Direction
// input     in_valid/in_ready, in_data_byte,        in
//           in_message_start
// result    out_valid/out_ready, out_byte           out
// config    cfg_we, cfg_index, cfg_wdata            in
//
// A byte is accepted, then the registered table read loads the output register;
// no new byte is taken until that result has been loaded into the output register.
// Reset (rst_n, synchronous, active low) and every key or mode write mark the
// tables stale; a rebuild (seed load, identity fill, 256 LCG swaps on the
// single-read forward table, inverse fill) then runs before any byte is taken.
// A write during the rebuild restarts it.
// The output register holds a result under stall; in_ready is low in the cycle
// after each accept and also while that register is full and not being taken.
module keyed_byte_substitution_cipher
  import kbsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_message_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte
);

  kbsc_cmd_t  cmd;
  kbsc_stat_t st;

  kbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  kbsc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .cmd              (cmd),
    .st               (st)
  );

  a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !st.stale)
    else $error("item taken while tables are stale");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item produced no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result is stalled");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready && st.stale)
    else $error("config write did not force a rebuild");

endmodule
